@@ hdl/brc_pkg.sv @@
// ----------------------------------------------------------------------------
// Balance robot controller package
// Shared widths, register indexes, configuration record and sequencer codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package brc_pkg;

  // Field widths
  localparam int TILT_W  = 17;
  localparam int ENC_W   = 16;
  localparam int GAIN_W  = 16;
  localparam int CMD_W   = 9;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  // Internal widths
  localparam int FILT_W   = 33;
  localparam int ACC_W    = 36;
  localparam int DTILT_W  = 18;
  localparam int DWHEEL_W = 10;
  localparam int MUL_AW   = 33;
  localparam int MUL_BW   = 17;
  localparam int PROD_W   = MUL_AW + MUL_BW;

  // Constants
  localparam logic signed [TILT_W-1:0] TILT_LIMIT     = 17'sd11520;
  localparam logic signed [TILT_W-1:0] TILT_LIMIT_NEG = -17'sd11520;
  localparam logic signed [MUL_BW-1:0] COEF_OLD       = 17'sd58982;
  localparam logic signed [MUL_BW-1:0] COEF_NEW       = 17'sd6554;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ANGLE_RATE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_ANGLE      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_WHEEL_RATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_WHEEL      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_STEER      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_BIAS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_BIAS       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_RIGHT_BIAS      = 3'd7;

  typedef struct packed {
    logic signed [GAIN_W-1:0] gain_angle_rate;
    logic signed [GAIN_W-1:0] gain_angle;
    logic signed [GAIN_W-1:0] gain_wheel_rate;
    logic signed [GAIN_W-1:0] gain_wheel;
    logic signed [GAIN_W-1:0] gain_steer;
    logic signed [CMD_W-1:0]  drive_bias;
    logic signed [CMD_W-1:0]  left_bias;
    logic signed [CMD_W-1:0]  right_bias;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    gain_angle_rate: 16'sd15360,
    gain_angle:      16'sd6144,
    gain_wheel_rate: 16'sd2176,
    gain_wheel:      16'sd1331,
    gain_steer:      16'sd0,
    drive_bias:      9'sd0,
    left_bias:       9'sd0,
    right_bias:      9'sd0
  };

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_LAUNCH,
    S_WAIT,
    S_SPEED,
    S_TORQUE,
    S_CLAMP,
    S_BIAS,
    S_EMIT
  } state_t;

  // Multiply steps, in issue order
  typedef enum logic [3:0] {
    OP_FILT_L_OLD,
    OP_FILT_L_NEW,
    OP_FILT_R_OLD,
    OP_FILT_R_NEW,
    OP_DTILT,
    OP_TILT,
    OP_DWHEEL,
    OP_WHEEL,
    OP_STEER
  } op_t;

endpackage

`default_nettype wire

@@ hdl/brc_in_if.sv @@
// ----------------------------------------------------------------------------
// Balance robot controller input channel
// One control tick: pitch angle and the two raw wheel encoder speeds.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface brc_in_if
  import brc_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic signed [TILT_W-1:0] tilt;
  logic signed [ENC_W-1:0]  enc_left;
  logic signed [ENC_W-1:0]  enc_right;

  modport source (output valid, output tilt, output enc_left, output enc_right,
                  input ready);
  modport sink (input valid, input tilt, input enc_left, input enc_right,
                output ready);
endinterface

`default_nettype wire

@@ hdl/brc_out_if.sv @@
// ----------------------------------------------------------------------------
// Balance robot controller result channel
// New motor command pair and the tilt cutoff flag.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface brc_out_if
  import brc_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] drive_left;
  logic signed [CMD_W-1:0] drive_right;
  logic                    fallen;

  modport source (output valid, output drive_left, output drive_right,
                  output fallen, input ready);
  modport sink (input valid, input drive_left, input drive_right,
                input fallen, output ready);
endinterface

`default_nettype wire

@@ hdl/brc_ser_mul.sv @@
// ----------------------------------------------------------------------------
// Balance robot controller serial multiplier
// Signed shift-add multiplier, one multiplier bit per cycle, top bit weighted
// negative. Product holds until the next start.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brc_ser_mul #(
  parameter int AW = 33,
  parameter int BW = 17
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic signed [AW-1:0] a,
  input  wire logic signed [BW-1:0] b,
  output logic                      busy,
  output logic                      done,
  output logic signed [AW+BW-1:0]   prod
);

  localparam int CNT_W = $clog2(BW + 1);

  logic signed [AW-1:0] a_r;
  logic signed [AW-1:0] hi_r;
  logic [BW-1:0]        lo_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r;
  logic                 done_r;

  logic signed [AW:0] addend;
  logic signed [AW:0] sum;
  logic               last;

  always_comb begin
    addend = lo_r[0] ? {a_r[AW-1], a_r} : '0;
    last   = (cnt_r == CNT_W'(BW - 1));
    // sign bit of the multiplier carries negative weight
    sum    = last ? ({hi_r[AW-1], hi_r} - addend) : ({hi_r[AW-1], hi_r} + addend);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      a_r  <= a;
      hi_r <= '0;
      lo_r <= b;
    end else if (busy_r) begin
      hi_r <= sum[AW:1];
      lo_r <= {sum[0], lo_r[BW-1:1]};
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign prod = {hi_r, lo_r};

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ($past(busy_r) && !busy_r))
    else $error("product ready without a running multiply");

endmodule

`default_nettype wire

@@ hdl/brc_core.sv @@
// ----------------------------------------------------------------------------
// Balance robot controller core
// Sequencer and datapath: wheel filters, state feedback torque, steering,
// offsets, clamps, dead zone and change detection, with the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module brc_core
  import brc_pkg::*;
#(
  parameter int DEAD_BAND = 20
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire cfg_t                     cfg,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [TILT_W-1:0] in_tilt,
  input  wire logic signed [ENC_W-1:0]  in_enc_left,
  input  wire logic signed [ENC_W-1:0]  in_enc_right,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [CMD_W-1:0]       out_left,
  output logic signed [CMD_W-1:0]       out_right,
  output logic                          out_fallen
);

  localparam logic [CMD_W-1:0] DB_U = CMD_W'(DEAD_BAND);

  function automatic logic signed [CMD_W-1:0] clamp_cmd(input logic signed [19:0] v);
    logic signed [CMD_W-1:0] res;
    if (v > 20'sd255)       res = 9'sd255;
    else if (v < -20'sd255) res = -9'sd255;
    else                    res = v[CMD_W-1:0];
    return res;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    logic signed [15:0] res;
    if (v > 20'sd32767)       res = 16'sh7FFF;
    else if (v < -20'sd32768) res = 16'sh8000;
    else                      res = v[15:0];
    return res;
  endfunction

  function automatic logic signed [CMD_W-1:0] squelch(input logic signed [CMD_W-1:0] v);
    logic [CMD_W-1:0] mag;
    mag = v[CMD_W-1] ? CMD_W'(-v) : CMD_W'(v);
    return ((mag != '0) && (mag < DB_U)) ? '0 : v;
  endfunction

  function automatic op_t next_op(input op_t op);
    op_t res;
    case (op)
      OP_FILT_L_OLD: res = OP_FILT_L_NEW;
      OP_FILT_L_NEW: res = OP_FILT_R_OLD;
      OP_FILT_R_OLD: res = OP_FILT_R_NEW;
      OP_FILT_R_NEW: res = OP_DTILT;
      OP_DTILT:      res = OP_TILT;
      OP_TILT:       res = OP_DWHEEL;
      OP_DWHEEL:     res = OP_WHEEL;
      OP_WHEEL:      res = OP_STEER;
      default:       res = OP_STEER;
    endcase
    return res;
  endfunction

  state_t state_r, state_nxt;
  op_t    op_r;

  logic signed [TILT_W-1:0]  tilt_r;
  logic signed [ENC_W-1:0]   el_r;
  logic signed [ENC_W-1:0]   er_r;
  logic signed [FILT_W-1:0]  filt_l_r;
  logic signed [FILT_W-1:0]  filt_r_r;
  logic signed [FILT_W-1:0]  tmp_r;
  logic signed [TILT_W-1:0]  prev_tilt_r;
  logic signed [CMD_W-1:0]   prev_wheel_r;
  logic signed [CMD_W-1:0]   sl_r;
  logic signed [CMD_W-1:0]   sr_r;
  logic signed [CMD_W-1:0]   wheel_r;
  logic signed [ACC_W-1:0]   acc_r;
  logic signed [15:0]        steer_r;
  logic signed [15:0]        torque_r;
  logic signed [CMD_W-1:0]   l0_r;
  logic signed [CMD_W-1:0]   r0_r;
  logic signed [CMD_W-1:0]   cmd_l_r;
  logic signed [CMD_W-1:0]   cmd_r_r;
  logic                      fallen_r;
  logic signed [CMD_W-1:0]   last_l_r;
  logic signed [CMD_W-1:0]   last_r_r;
  logic                      out_valid_r;
  logic signed [CMD_W-1:0]   out_left_r;
  logic signed [CMD_W-1:0]   out_right_r;
  logic                      out_fallen_r;

  logic                      cut;
  logic                      mul_start;
  logic                      mul_busy;
  logic                      mul_done;
  logic signed [MUL_AW-1:0]  mul_a;
  logic signed [MUL_BW-1:0]  mul_b;
  logic signed [PROD_W-1:0]  prod;
  logic                      slot_free;
  logic                      pair_new;
  logic                      out_load;

  logic signed [DTILT_W-1:0]  dtilt;
  logic signed [DWHEEL_W-1:0] dwheel;
  logic signed [DWHEEL_W-1:0] sdiff;
  logic [33:0]                q_old;
  logic [18:0]                q_steer;
  logic [19:0]                q_torque;
  logic signed [16:0]         ql;
  logic signed [16:0]         qr;
  logic signed [DWHEEL_W-1:0] wsum;
  logic signed [DWHEEL_W-1:0] wadj;
  logic signed [10:0]         lb_sum;
  logic signed [10:0]         rb_sum;

  assign cut = (in_tilt > TILT_LIMIT) || (in_tilt < TILT_LIMIT_NEG);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:   if (in_valid) state_nxt = cut ? S_EMIT : S_LAUNCH;
      S_LAUNCH: state_nxt = S_WAIT;
      S_WAIT: begin
        if (mul_done) begin
          if (op_r == OP_FILT_R_NEW) state_nxt = S_SPEED;
          else if (op_r == OP_STEER) state_nxt = S_TORQUE;
          else                       state_nxt = S_LAUNCH;
        end
      end
      S_SPEED:  state_nxt = S_LAUNCH;
      S_TORQUE: state_nxt = S_CLAMP;
      S_CLAMP:  state_nxt = S_BIAS;
      S_BIAS:   state_nxt = S_EMIT;
      S_EMIT:   if (slot_free) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    slot_free = !out_valid_r || out_ready;
    pair_new  = (cmd_l_r != last_l_r) || (cmd_r_r != last_r_r);
    out_load  = 1'b0;
    case (state_r)
      S_IDLE:   in_ready  = 1'b1;
      S_LAUNCH: mul_start = 1'b1;
      S_EMIT:   out_load  = slot_free && pair_new;
      default:  ;
    endcase
  end

  // Multiplier operand select
  always_comb begin
    dtilt  = DTILT_W'(tilt_r) - DTILT_W'(prev_tilt_r);
    dwheel = DWHEEL_W'(wheel_r) - DWHEEL_W'(prev_wheel_r);
    sdiff  = DWHEEL_W'(sl_r) - DWHEEL_W'(sr_r);
    mul_a  = '0;
    mul_b  = '0;
    case (op_r)
      OP_FILT_L_OLD: begin mul_a = filt_l_r;         mul_b = COEF_OLD; end
      OP_FILT_L_NEW: begin mul_a = MUL_AW'(el_r);    mul_b = COEF_NEW; end
      OP_FILT_R_OLD: begin mul_a = filt_r_r;         mul_b = COEF_OLD; end
      OP_FILT_R_NEW: begin mul_a = MUL_AW'(er_r);    mul_b = COEF_NEW; end
      OP_DTILT: begin
        mul_a = MUL_AW'(dtilt);
        mul_b = MUL_BW'(cfg.gain_angle_rate);
      end
      OP_TILT: begin
        mul_a = MUL_AW'(tilt_r);
        mul_b = MUL_BW'(cfg.gain_angle);
      end
      OP_DWHEEL: begin
        mul_a = MUL_AW'(dwheel);
        mul_b = MUL_BW'(cfg.gain_wheel_rate);
      end
      OP_WHEEL: begin
        mul_a = MUL_AW'(wheel_r);
        mul_b = MUL_BW'(cfg.gain_wheel);
      end
      OP_STEER: begin
        mul_a = MUL_AW'(sdiff);
        mul_b = MUL_BW'(cfg.gain_steer);
      end
      default: ;
    endcase
  end

  brc_ser_mul #(
    .AW (MUL_AW),
    .BW (MUL_BW)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .done  (mul_done),
    .prod  (prod)
  );

  // Truncating divides toward zero: add one when negative with a nonzero remainder
  always_comb begin
    q_old    = prod[PROD_W-2:16] + 34'(prod[PROD_W-1] && (prod[15:0] != '0));
    q_steer  = prod[26:8] + 19'(prod[26] && (prod[7:0] != '0));
    q_torque = acc_r[ACC_W-1:16] + 20'(acc_r[ACC_W-1] && (acc_r[15:0] != '0));
    ql       = $signed(filt_l_r[FILT_W-1:16] +
                       17'(filt_l_r[FILT_W-1] && (filt_l_r[15:0] != '0)));
    qr       = $signed(filt_r_r[FILT_W-1:16] +
                       17'(filt_r_r[FILT_W-1] && (filt_r_r[15:0] != '0)));
    wsum     = DWHEEL_W'(sl_r) + DWHEEL_W'(sr_r);
    wadj     = wsum + $signed({{(DWHEEL_W-1){1'b0}}, wsum[DWHEEL_W-1]});
    lb_sum   = 11'(l0_r) + 11'(cfg.drive_bias) + 11'(cfg.left_bias);
    rb_sum   = 11'(r0_r) + 11'(cfg.drive_bias) + 11'(cfg.right_bias);
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      op_r         <= OP_FILT_L_OLD;
      out_valid_r  <= 1'b0;
      filt_l_r     <= '0;
      filt_r_r     <= '0;
      prev_tilt_r  <= '0;
      prev_wheel_r <= '0;
      last_l_r     <= '0;
      last_r_r     <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_IDLE) begin
        op_r <= OP_FILT_L_OLD;
      end else if (state_r == S_WAIT && mul_done) begin
        op_r <= next_op(op_r);
        case (op_r)
          OP_FILT_L_NEW: filt_l_r <= tmp_r + prod[FILT_W-1:0];
          OP_FILT_R_NEW: filt_r_r <= tmp_r + prod[FILT_W-1:0];
          default: ;
        endcase
      end
      if (state_r == S_BIAS) begin
        prev_tilt_r  <= tilt_r;
        prev_wheel_r <= wheel_r;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        last_l_r    <= cmd_l_r;
        last_r_r    <= cmd_r_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          tilt_r   <= in_tilt;
          el_r     <= in_enc_left;
          er_r     <= in_enc_right;
          cmd_l_r  <= '0;
          cmd_r_r  <= '0;
          fallen_r <= cut;
        end
      end
      S_WAIT: begin
        if (mul_done) begin
          case (op_r)
            OP_FILT_L_OLD, OP_FILT_R_OLD: tmp_r <= q_old[FILT_W-1:0];
            OP_DTILT: begin
              acc_r   <= prod[ACC_W-1:0];
              wheel_r <= wadj[DWHEEL_W-1:1];
            end
            OP_TILT:   acc_r <= acc_r + prod[ACC_W-1:0];
            OP_DWHEEL, OP_WHEEL: acc_r <= acc_r + {prod[ACC_W-9:0], 8'b0};
            OP_STEER:  steer_r <= sat16(20'($signed(q_steer)));
            default: ;
          endcase
        end
      end
      S_SPEED: begin
        // left encoder counts the other way round
        sl_r <= clamp_cmd(20'sd0 - 20'(ql));
        sr_r <= clamp_cmd(20'(qr));
      end
      S_TORQUE: torque_r <= sat16($signed(q_torque));
      S_CLAMP: begin
        l0_r <= clamp_cmd(20'(torque_r) - 20'(steer_r));
        r0_r <= clamp_cmd(20'(torque_r));
      end
      S_BIAS: begin
        cmd_l_r <= squelch(clamp_cmd(20'(lb_sum)));
        cmd_r_r <= squelch(clamp_cmd(20'(rb_sum)));
      end
      default: ;
    endcase
    if (out_load) begin
      out_left_r   <= cmd_l_r;
      out_right_r  <= cmd_r_r;
      out_fallen_r <= fallen_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_left   = out_left_r;
  assign out_right  = out_right_r;
  assign out_fallen = out_fallen_r;

  a_cut_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && cut) |=>
      (state_r == S_EMIT && fallen_r && cmd_l_r == '0 && cmd_r_r == '0))
    else $error("tilt cutoff did not force a zero command");

  a_fallen_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_fallen_r) |-> (out_left_r == '0 && out_right_r == '0))
    else $error("fallen result carries a nonzero command");

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start |-> !mul_busy)
    else $error("multiply launched while the multiplier is busy");

  a_dead_band: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (squelch(out_left_r) == out_left_r &&
                     squelch(out_right_r) == out_right_r))
    else $error("result command inside the dead zone");

endmodule

`default_nettype wire

@@ hdl/balance_robot_controller.sv @@
// ----------------------------------------------------------------------------
// Balance robot controller
// Two-wheel self-balancing state feedback controller with configuration
// registers; one control tick in, a changed motor command pair out.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake          Contents
//  in_chan   sink       valid/ready        tilt, enc_left, enc_right
//  out_chan  source     valid/ready        drive_left, drive_right, fallen
//  cfg_*     write      cfg_we             cfg_idx selects, cfg_wdata value
//
//  Between its transfer and the earliest next transfer, a tick runs nine
//  multiplies in turn on one serial multiplier (one multiplier bit per cycle),
//  then the sequencing states. A tick past the tilt limit skips the multiplies.
//  Reset is synchronous, active low, and loads the register defaults.
//  A waiting result holds in the output register; the next tick is taken
//  meanwhile and stalls only at its own result when the register is still full.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module balance_robot_controller
  import brc_pkg::*;
#(
  parameter int DEAD_BAND = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  brc_in_if.sink                     in_chan,
  brc_out_if.source                  out_chan,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_GAIN_ANGLE_RATE: cfg_r.gain_angle_rate <= cfg_wdata;
        REG_GAIN_ANGLE:      cfg_r.gain_angle      <= cfg_wdata;
        REG_GAIN_WHEEL_RATE: cfg_r.gain_wheel_rate <= cfg_wdata;
        REG_GAIN_WHEEL:      cfg_r.gain_wheel      <= cfg_wdata;
        REG_GAIN_STEER:      cfg_r.gain_steer      <= cfg_wdata;
        REG_DRIVE_BIAS:      cfg_r.drive_bias      <= cfg_wdata[CMD_W-1:0];
        REG_LEFT_BIAS:       cfg_r.left_bias       <= cfg_wdata[CMD_W-1:0];
        REG_RIGHT_BIAS:      cfg_r.right_bias      <= cfg_wdata[CMD_W-1:0];
        default: ;
      endcase
    end
  end

  brc_core #(
    .DEAD_BAND (DEAD_BAND)
  ) u_core (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_chan.valid),
    .in_ready     (in_chan.ready),
    .in_tilt      (in_chan.tilt),
    .in_enc_left  (in_chan.enc_left),
    .in_enc_right (in_chan.enc_right),
    .out_valid    (out_chan.valid),
    .out_ready    (out_chan.ready),
    .out_left     (out_chan.drive_left),
    .out_right    (out_chan.drive_right),
    .out_fallen   (out_chan.fallen)
  );

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// Balance robot controller testbench
// Drives control ticks through the input channel, predicts each motor command
// update from a cycle-free model of the controller, and checks every transfer
// on the result channel in order. Register settings change between phases
// while the block is quiet. Backpressure and source gaps vary by phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import brc_pkg::*;

  localparam int     CMD_DEAD_BAND = 20;
  localparam longint TILT_MAX      = 11520;
  localparam longint LPF_KEEP      = 58982;
  localparam longint LPF_TAKE      = 6554;
  localparam longint CMD_MAX       = 255;
  localparam int     PHASE_TICKS   = 270;
  localparam int     SETTLE_CYCLES = 400;
  localparam int     N_SETTINGS    = 6;
  // about 1650 ticks, with stalls, taken several times over
  localparam longint CYCLE_LIMIT   = 3000000;

  typedef enum int {
    SET_STEER_BIAS,
    SET_GAIN_MAX,
    SET_GAIN_MIN,
    SET_GAIN_SMALL,
    SET_GAIN_RANDOM,
    SET_DEFAULT
  } setting_t;

  typedef struct packed {
    logic signed [TILT_W-1:0] tilt;
    logic signed [ENC_W-1:0]  enc_left;
    logic signed [ENC_W-1:0]  enc_right;
  } tick_t;

  typedef struct packed {
    logic signed [CMD_W-1:0] drive_left;
    logic signed [CMD_W-1:0] drive_right;
    logic                    fallen;
  } cmd_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  brc_in_if  in_if ();
  brc_out_if out_if ();

  balance_robot_controller #(
    .DEAD_BAND (CMD_DEAD_BAND)
  ) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if.sink),
    .out_chan  (out_if.source),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // Controller shadow state
  cfg_t   gains;
  longint lpf_left;
  longint lpf_right;
  longint tilt_prev;
  longint mean_prev;
  longint sent_left;
  longint sent_right;

  tick_t  tick_queue[$];
  cmd_t   predicted_cmds[$];
  tick_t  on_wire;
  cmd_t   want_cmd;

  int     ticks_queued;
  int     ticks_taken;
  int     cutoff_ticks;
  int     cmds_checked;
  int     fallen_cmds;
  int     faults;
  int     src_idle_pct;
  int     snk_idle_pct;
  longint cycle_count;
  int     walk_tilt;
  int     walk_left;
  int     walk_right;

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic longint squelch(longint v);
    return (v > -CMD_DEAD_BAND && v < CMD_DEAD_BAND) ? 0 : v;
  endfunction

  function automatic void post_command(longint l, longint r, logic fallen);
    cmd_t c;
    // drop a pair that matches the last one sent
    if (l == sent_left && r == sent_right) return;
    sent_left     = l;
    sent_right    = r;
    c.drive_left  = l[CMD_W-1:0];
    c.drive_right = r[CMD_W-1:0];
    c.fallen      = fallen;
    predicted_cmds.push_back(c);
  endfunction

  function automatic void predict_command(tick_t t);
    longint tilt, el, er, sl, sr, wheel, dtilt, dwheel, acc, torque, steer, l, r;
    tilt = longint'(t.tilt);
    el   = longint'(t.enc_left);
    er   = longint'(t.enc_right);
    if (tilt > TILT_MAX || tilt < -TILT_MAX) begin
      cutoff_ticks++;
      post_command(0, 0, 1'b1);
      return;
    end
    lpf_left  = (lpf_left * LPF_KEEP) / 65536 + el * LPF_TAKE;
    lpf_right = (lpf_right * LPF_KEEP) / 65536 + er * LPF_TAKE;
    // left encoder counts backward
    sl = clip(-(lpf_left / 65536), -CMD_MAX, CMD_MAX);
    sr = clip(lpf_right / 65536, -CMD_MAX, CMD_MAX);
    dtilt     = tilt - tilt_prev;
    tilt_prev = tilt;
    wheel     = (sl + sr) / 2;
    dwheel    = wheel - mean_prev;
    mean_prev = wheel;
    // whole sum in Q16, truncated once
    acc = dtilt * longint'(gains.gain_angle_rate) + tilt * longint'(gains.gain_angle)
        + (dwheel * longint'(gains.gain_wheel_rate)
           + wheel * longint'(gains.gain_wheel)) * 256;
    torque = clip(acc / 65536, -32768, 32767);
    steer  = clip((longint'(gains.gain_steer) * (sl - sr)) / 256, -32768, 32767);
    l = clip(clip(torque - steer, -32768, 32767), -CMD_MAX, CMD_MAX);
    r = clip(torque, -CMD_MAX, CMD_MAX);
    l = clip(l + longint'(gains.drive_bias) + longint'(gains.left_bias), -CMD_MAX, CMD_MAX);
    r = clip(r + longint'(gains.drive_bias) + longint'(gains.right_bias), -CMD_MAX, CMD_MAX);
    post_command(squelch(l), squelch(r), 1'b0);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] widen(logic signed [CMD_W-1:0] b);
    return {{(CFG_DATA_W - CMD_W){b[CMD_W-1]}}, b};
  endfunction

  function automatic cfg_t pick_setting(setting_t which);
    cfg_t s;
    s = CFG_RESET;
    case (which)
      SET_STEER_BIAS: begin
        s.gain_steer = 16'sd256;
        s.drive_bias = 9'sd30;
        s.left_bias  = -9'sd40;
        s.right_bias = 9'sd25;
      end
      SET_GAIN_MAX: begin
        s.gain_angle_rate = 16'h7FFF;
        s.gain_angle      = 16'h7FFF;
        s.gain_wheel_rate = 16'h7FFF;
        s.gain_wheel      = 16'h7FFF;
        s.gain_steer      = 16'h7FFF;
        s.drive_bias      = 9'sd255;
        s.left_bias       = -9'sd255;
        s.right_bias      = 9'sd255;
      end
      SET_GAIN_MIN: begin
        s.gain_angle_rate = 16'h8000;
        s.gain_angle      = 16'h8000;
        s.gain_wheel_rate = 16'h8000;
        s.gain_wheel      = 16'h8000;
        s.gain_steer      = 16'h8000;
        s.drive_bias      = -9'sd255;
        s.left_bias       = 9'sd255;
        s.right_bias      = -9'sd255;
      end
      SET_GAIN_SMALL: begin
        s.gain_angle_rate = GAIN_W'(rand_between(-4096, 4096));
        s.gain_angle      = GAIN_W'(rand_between(-4096, 4096));
        s.gain_wheel_rate = GAIN_W'(rand_between(-4096, 4096));
        s.gain_wheel      = GAIN_W'(rand_between(-4096, 4096));
        s.gain_steer      = GAIN_W'(rand_between(-4096, 4096));
        s.drive_bias      = CMD_W'(rand_between(-60, 60));
        s.left_bias       = CMD_W'(rand_between(-60, 60));
        s.right_bias      = CMD_W'(rand_between(-60, 60));
      end
      SET_GAIN_RANDOM: begin
        s.gain_angle_rate = GAIN_W'(rand_between(-32768, 32767));
        s.gain_angle      = GAIN_W'(rand_between(-32768, 32767));
        s.gain_wheel_rate = GAIN_W'(rand_between(-32768, 32767));
        s.gain_wheel      = GAIN_W'(rand_between(-32768, 32767));
        s.gain_steer      = GAIN_W'(rand_between(-32768, 32767));
        s.drive_bias      = CMD_W'(rand_between(-255, 255));
        s.left_bias       = CMD_W'(rand_between(-255, 255));
        s.right_bias      = CMD_W'(rand_between(-255, 255));
      end
      default: ;
    endcase
    return s;
  endfunction

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      REG_GAIN_ANGLE_RATE: gains.gain_angle_rate = val;
      REG_GAIN_ANGLE:      gains.gain_angle      = val;
      REG_GAIN_WHEEL_RATE: gains.gain_wheel_rate = val;
      REG_GAIN_WHEEL:      gains.gain_wheel      = val;
      REG_GAIN_STEER:      gains.gain_steer      = val;
      REG_DRIVE_BIAS:      gains.drive_bias      = val[CMD_W-1:0];
      REG_LEFT_BIAS:       gains.left_bias       = val[CMD_W-1:0];
      REG_RIGHT_BIAS:      gains.right_bias      = val[CMD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(cfg_t s);
    write_reg(REG_GAIN_ANGLE_RATE, s.gain_angle_rate);
    write_reg(REG_GAIN_ANGLE, s.gain_angle);
    write_reg(REG_GAIN_WHEEL_RATE, s.gain_wheel_rate);
    write_reg(REG_GAIN_WHEEL, s.gain_wheel);
    write_reg(REG_GAIN_STEER, s.gain_steer);
    write_reg(REG_DRIVE_BIAS, widen(s.drive_bias));
    write_reg(REG_LEFT_BIAS, widen(s.left_bias));
    write_reg(REG_RIGHT_BIAS, widen(s.right_bias));
    cfg_we <= 1'b0;
  endtask

  task automatic push_tick(int tilt, int el, int er);
    tick_t t;
    t.tilt      = TILT_W'(tilt);
    t.enc_left  = ENC_W'(el);
    t.enc_right = ENC_W'(er);
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  task automatic push_random_tick();
    int roll;
    int sign;
    roll = $urandom_range(99);
    sign = $urandom_range(1) ? 1 : -1;
    if (roll < 55) begin
      // a robot wobbling near upright: slow drift with noise
      walk_tilt  = int'(clip(walk_tilt + rand_between(-300, 300), -TILT_MAX, TILT_MAX));
      walk_left  = int'(clip(walk_left + rand_between(-40, 40), -400, 400));
      walk_right = int'(clip(walk_right + rand_between(-40, 40), -400, 400));
      push_tick(walk_tilt, walk_left + rand_between(-8, 8), walk_right + rand_between(-8, 8));
    end else if (roll < 70) begin
      push_tick(rand_between(-11520, 11520), rand_between(-400, 400), rand_between(-400, 400));
    end else if (roll < 80) begin
      push_tick(sign * rand_between(11521, 46080), rand_between(-400, 400),
                rand_between(-400, 400));
    end else if (roll < 88) begin
      push_tick(sign * rand_between(11519, 11521), rand_between(-50, 50),
                rand_between(-50, 50));
    end else begin
      push_tick(rand_between(-46080, 46080), rand_between(-32768, 32767),
                rand_between(-32768, 32767));
    end
  endtask

  task automatic wait_quiet();
    while (ticks_taken != ticks_queued) @(posedge clk);
    while (predicted_cmds.size() != 0) @(posedge clk);
    // a tick that changes nothing may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("testbench failed");
      $finish;
    end
  end

  // Input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid     <= 1'b0;
      in_if.tilt      <= '0;
      in_if.enc_left  <= '0;
      in_if.enc_right <= '0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        predict_command(on_wire);
        ticks_taken++;
      end
      // hold an offered tick until its transfer
      if (!in_if.valid || in_if.ready) begin
        if (tick_queue.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          on_wire = tick_queue.pop_front();
          in_if.valid     <= 1'b1;
          in_if.tilt      <= on_wire.tilt;
          in_if.enc_left  <= on_wire.enc_left;
          in_if.enc_right <= on_wire.enc_right;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (predicted_cmds.size() == 0) begin
          if (faults < 10)
            $display("unexpected command: left %0d right %0d fallen %0b",
                     out_if.drive_left, out_if.drive_right, out_if.fallen);
          faults++;
        end else begin
          want_cmd = predicted_cmds.pop_front();
          cmds_checked++;
          if (want_cmd.fallen) fallen_cmds++;
          if (out_if.drive_left !== want_cmd.drive_left ||
              out_if.drive_right !== want_cmd.drive_right ||
              out_if.fallen !== want_cmd.fallen) begin
            if (faults < 10)
              $display("command %0d: expected %0d/%0d/%0b, got %0d/%0d/%0b",
                       cmds_checked, want_cmd.drive_left, want_cmd.drive_right,
                       want_cmd.fallen, out_if.drive_left, out_if.drive_right,
                       out_if.fallen);
            faults++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin : stimulus
    cfg_t setting;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    gains           = CFG_RESET;
    src_idle_pct    = 7;
    snk_idle_pct    = 50;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed ticks under the reset gains
    push_tick(0, 0, 0);
    push_tick(256, 10, -10);
    push_tick(-256, -10, 10);
    push_tick(11520, 32767, -32768);
    push_tick(-11520, -32768, 32767);
    push_tick(11521, 0, 0);
    push_tick(-11521, 0, 0);
    push_tick(46080, 0, 0);
    push_tick(-46080, 0, 0);
    push_tick(40, 0, 0);
    push_tick(-40, 0, 0);
    push_tick(60, 5, 5);
    push_tick(60, 5, 5);
    push_tick(2560, 300, 300);
    push_tick(-2560, -300, -300);
    push_tick(0, 0, 0);
    push_tick(0, 0, 0);
    push_tick(1000, 32767, 32767);
    push_tick(-1000, -32768, -32768);
    push_tick(0, 0, 0);
    wait_quiet();

    for (int ph = 0; ph < N_SETTINGS; ph++) begin
      if (ph == 2) begin
        src_idle_pct = 50;
        snk_idle_pct = 7;
      end else if (ph == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      setting = pick_setting(setting_t'(ph));
      apply_setting(setting);
      repeat (PHASE_TICKS) push_random_tick();
      wait_quiet();
    end

    $display("covered %0d ticks, %0d past the tilt limit, over reset gains and %0d settings",
             ticks_taken, cutoff_ticks, N_SETTINGS);
    $display("checked %0d command updates, %0d of them fallen; %0d mismatches",
             cmds_checked, fallen_cmds, faults);
    if (faults == 0 && predicted_cmds.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
